### rtl/lge_pkg.sv
// lge_pkg: shared types and constants of the Life grid generation engine.
// Used by lge_ctrl, lge_datapath and the top level; depends on nothing.
package lge_pkg;

  // Grid store depth the row index width is built around
  localparam int GRID_DEPTH   = 64;
  localparam int GRID_AW      = 6;
  localparam int ROW_W        = 64;
  localparam int CNT_W        = 7;
  localparam int GEN_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Register reset values
  localparam logic [CNT_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [CNT_W-1:0] COL_COUNT_RST = 7'd64;
  localparam logic             WRAP_RST      = 1'b0;
  localparam logic [GEN_W-1:0] GEN_COUNT_RST = 16'd500;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_COL_COUNT = 2'd1,
    CFG_WRAP      = 2'd2,
    CFG_GEN_COUNT = 2'd3
  } cfg_idx_e;

  // Controller to datapath command; tag_* fields travel with a read and act
  // in the next cycle, when its data returns.
  typedef struct packed {
    logic               load_we;
    logic [GRID_AW-1:0] load_row;
    logic               bank;
    logic               rd_en;
    logic [GRID_AW-1:0] rd_row;
    logic               tag_gen;
    logic               tag_cmp;
    logic               tag_up_zero;
    logic               tag_down_zero;
    logic               tag_emit;
    logic               tag_last;
    logic [GRID_AW-1:0] tag_row;
    logic [CNT_W-1:0]   cols;
    logic               wrap;
  } lge_cmd_t;

  typedef struct packed {
    logic out_free;
  } lge_status_t;

endpackage

### rtl/lge_ctrl.sv
// lge_ctrl: load / generation / emit sequencer and configuration registers.
// Depends on lge_pkg; drives lge_datapath through lge_cmd_t.
module lge_ctrl #(
  parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                row_valid_i,
  output logic                                row_stall_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lge_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lge_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  lge_pkg::lge_status_t                status_i,
  output lge_pkg::lge_cmd_t                   cmd_o
);
  import lge_pkg::*;

  localparam int ROW_LIMIT = (MAX_ROWS < GRID_DEPTH) ? MAX_ROWS : GRID_DEPTH;
  localparam int COL_LIMIT = (MAX_COLS < ROW_W) ? MAX_COLS : ROW_W;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_GEN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] row_count_q, col_count_q;
  logic             wrap_q;
  logic [GEN_W-1:0] gen_count_q;
  logic [CNT_W-1:0] rows_loaded_q, rows_loaded_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] emit_q, emit_d;
  logic [GEN_W-1:0] gen_q, gen_d;
  logic             bank_q, bank_d;
  logic             inflight_q, inflight_d;

  logic [CNT_W-1:0] rows, cols, rows_m1, step_m1, step_m2, rl, rl_p1;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (row_count_q == '0) begin
      rows = 7'd1;
    end else if (row_count_q > CNT_W'(ROW_LIMIT)) begin
      rows = CNT_W'(ROW_LIMIT);
    end else begin
      rows = row_count_q;
    end
    if (col_count_q == '0) begin
      cols = 7'd1;
    end else if (col_count_q > CNT_W'(COL_LIMIT)) begin
      cols = CNT_W'(COL_LIMIT);
    end else begin
      cols = col_count_q;
    end
  end

  assign rows_m1 = rows - 7'd1;
  assign step_m1 = step_q - 7'd1;
  assign step_m2 = step_q - 7'd2;
  // restart the load when the row count dropped under the rows already in
  assign rl      = (rows_loaded_q >= rows) ? '0 : rows_loaded_q;
  assign rl_p1   = rl + 7'd1;

  always_comb begin
    state_d       = state_q;
    rows_loaded_d = rows_loaded_q;
    step_d        = step_q;
    emit_d        = emit_q;
    gen_d         = gen_q;
    bank_d        = bank_q;
    inflight_d    = 1'b0;
    row_stall_o   = (state_q != ST_LOAD);
    cmd_o         = '0;
    cmd_o.bank    = bank_q;
    cmd_o.cols    = cols;
    cmd_o.wrap    = wrap_q;
    case (state_q)
      ST_LOAD: begin
        if (row_valid_i) begin
          cmd_o.load_we  = 1'b1;
          cmd_o.load_row = rl[GRID_AW-1:0];
          if (rl_p1 >= rows) begin
            rows_loaded_d = '0;
            gen_d         = '0;
            step_d        = '0;
            emit_d        = '0;
            state_d       = (gen_count_q == '0) ? ST_EMIT : ST_GEN;
          end else begin
            rows_loaded_d = rl_p1;
          end
        end
      end
      ST_GEN: begin
        // read order: last row, rows 0..rows-1, row 0 again
        cmd_o.rd_en   = 1'b1;
        cmd_o.tag_gen = 1'b1;
        if (step_q == '0) begin
          cmd_o.rd_row = rows_m1[GRID_AW-1:0];
        end else if (step_q == rows + 7'd1) begin
          cmd_o.rd_row = '0;
        end else begin
          cmd_o.rd_row = step_m1[GRID_AW-1:0];
        end
        cmd_o.tag_cmp       = (step_q >= 7'd2);
        cmd_o.tag_row       = step_m2[GRID_AW-1:0];
        cmd_o.tag_up_zero   = !wrap_q && (step_m2 == '0);
        cmd_o.tag_down_zero = !wrap_q && (step_m2 == rows_m1);
        if (step_q == rows + 7'd1) begin
          step_d  = '0;
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 7'd1;
        end
      end
      ST_DRAIN: begin
        // last row of the generation is written at the end of this cycle
        bank_d = ~bank_q;
        gen_d  = gen_q + 16'd1;
        if (gen_q + 16'd1 == gen_count_q) begin
          emit_d  = '0;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_GEN;
        end
      end
      ST_EMIT: begin
        if (!inflight_q && status_i.out_free) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_row   = emit_q[GRID_AW-1:0];
          cmd_o.tag_emit = 1'b1;
          cmd_o.tag_row  = emit_q[GRID_AW-1:0];
          cmd_o.tag_last = (emit_q == rows_m1);
          inflight_d     = 1'b1;
          emit_d         = emit_q + 7'd1;
          if (emit_q == rows_m1) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      rows_loaded_q <= '0;
      step_q        <= '0;
      emit_q        <= '0;
      gen_q         <= '0;
      bank_q        <= 1'b0;
      inflight_q    <= 1'b0;
      row_count_q   <= ROW_COUNT_RST;
      col_count_q   <= COL_COUNT_RST;
      wrap_q        <= WRAP_RST;
      gen_count_q   <= GEN_COUNT_RST;
    end else begin
      state_q       <= state_d;
      rows_loaded_q <= rows_loaded_d;
      step_q        <= step_d;
      emit_q        <= emit_d;
      gen_q         <= gen_d;
      bank_q        <= bank_d;
      inflight_q    <= inflight_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ROW_COUNT: row_count_q <= cfg_data_i[CNT_W-1:0];
          CFG_COL_COUNT: col_count_q <= cfg_data_i[CNT_W-1:0];
          CFG_WRAP:      wrap_q      <= cfg_data_i[0];
          CFG_GEN_COUNT: gen_count_q <= cfg_data_i[GEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### rtl/lge_datapath.sv
// lge_datapath: ping-pong grid memory, three-row window, B3/S23 row update
// and the result register. Depends on lge_pkg; commanded by lge_ctrl.
module lge_datapath #(
  parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lge_pkg::lge_cmd_t             cmd_i,
  output lge_pkg::lge_status_t          status_o,
  input  logic [lge_pkg::ROW_W-1:0]     row_cells_i,
  output logic                          result_valid_o,
  input  logic                          result_stall_i,
  output logic [lge_pkg::ROW_W-1:0]     result_row_cells_o,
  output logic [lge_pkg::GRID_AW-1:0]   result_row_index_o,
  output logic                          last_row_o
);
  import lge_pkg::*;

  localparam int ROW_LIMIT = (MAX_ROWS < GRID_DEPTH) ? MAX_ROWS : GRID_DEPTH;
  localparam int RW        = $clog2(ROW_LIMIT);
  localparam int AW        = RW + 1;
  localparam int DEPTH     = 2 ** AW;
  localparam int CW        = $clog2(MAX_COLS);

  typedef logic [MAX_COLS-1:0] row_t;

  row_t mem_q [DEPTH];
  row_t rdata_q, up_q, cur_q;
  lge_cmd_t cmd_q;

  row_t               ld_mask, cp_mask, u, c, d, next_row, wdata;
  logic [CW-1:0]      cidx;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  row_t               ul, ur, cl, cr, dl, dr;

  logic               out_valid_q;
  row_t               out_cells_q;
  logic [GRID_AW-1:0] out_idx_q;
  logic               out_last_q;

  function automatic row_t nb_left(row_t r, logic w, logic [CW-1:0] ci);
    nb_left = {r[MAX_COLS-2:0], w & r[ci]};
  endfunction

  function automatic row_t nb_right(row_t r, logic w, logic [CW-1:0] ci);
    row_t wrap_bit;
    wrap_bit = row_t'(w & r[0]) << ci;
    nb_right = (r >> 1) | wrap_bit;
  endfunction

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_mask
    assign ld_mask[j] = (CNT_W'(j) < cmd_i.cols);
    assign cp_mask[j] = (CNT_W'(j) < cmd_q.cols);
  end

  assign cidx = CW'(cmd_q.cols - 7'd1);
  assign u    = cmd_q.tag_up_zero   ? '0 : (up_q & cp_mask);
  assign c    = cur_q & cp_mask;
  assign d    = cmd_q.tag_down_zero ? '0 : (rdata_q & cp_mask);

  assign ul = nb_left(u, cmd_q.wrap, cidx);
  assign ur = nb_right(u, cmd_q.wrap, cidx);
  assign cl = nb_left(c, cmd_q.wrap, cidx);
  assign cr = nb_right(c, cmd_q.wrap, cidx);
  assign dl = nb_left(d, cmd_q.wrap, cidx);
  assign dr = nb_right(d, cmd_q.wrap, cidx);

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
    logic [3:0] sum;
    assign sum = {3'b0, ul[j]} + {3'b0, u[j]} + {3'b0, ur[j]} + {3'b0, cl[j]}
               + {3'b0, cr[j]} + {3'b0, dl[j]} + {3'b0, d[j]} + {3'b0, dr[j]};
    assign next_row[j] = cp_mask[j] & ((sum == 4'd3) | (c[j] & (sum == 4'd2)));
  end

  // single write port: load rows into the current bank, updated rows into the other bank
  assign we    = cmd_i.load_we | cmd_q.tag_cmp;
  assign waddr = cmd_i.load_we ? {cmd_i.bank, cmd_i.load_row[RW-1:0]}
                               : {~cmd_q.bank, cmd_q.tag_row[RW-1:0]};
  assign wdata = cmd_i.load_we ? (row_cells_i[MAX_COLS-1:0] & ld_mask) : next_row;
  assign raddr = {cmd_i.bank, cmd_i.rd_row[RW-1:0]};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_q.tag_gen) begin
      up_q  <= cur_q;
      cur_q <= rdata_q;
    end
    if (cmd_q.tag_emit) begin
      out_cells_q <= rdata_q & cp_mask;
      out_idx_q   <= cmd_q.tag_row;
      out_last_q  <= cmd_q.tag_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cmd_q <= cmd_i;
      if (cmd_q.tag_emit) begin
        out_valid_q <= 1'b1;
      end else if (!result_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free   = !out_valid_q || !result_stall_i;
  assign result_valid_o      = out_valid_q;
  assign result_row_cells_o  = ROW_W'(out_cells_q);
  assign result_row_index_o  = out_idx_q;
  assign last_row_o          = out_last_q;

endmodule

### rtl/life_grid_generation_engine.sv
// Top level of the Conway Life (B3/S23) grid generation engine.
// Depends on lge_pkg, lge_ctrl and lge_datapath.
//
// Usage:
//   Input channel (row_valid_i / row_stall_o / row_cells_i): one word per grid
//   row, bit j = column j. Rows are taken one per cycle while loading; the
//   word that completes row_count rows starts the run and the input stalls
//   until the last result word has been read out of the grid memory.
//   Config channel (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i):
//   always ready; index 0 row_count, 1 col_count, 2 wrap_edges,
//   3 generation_count. Write it only while no grid is in flight.
//   Result channel (result_valid_o / result_stall_i): one word per row in
//   row order with its index, last_row_o set on the final row.
// Sweep and emission:
//   Each generation sweeps the grid memory once: one read per row plus the
//   wrap rows at both ends, then a write drain.
//   The single read port feeds the result register; a new result read issues
//   only once the previous word has reached it, so words leave with gaps.
//   Emission starts after all generation_count generations have run.
//   A stalled result word holds; emission pauses behind it.
// Reset: asynchronous, active low; clears the load position and control,
//   restores register defaults. Grid memory is not cleared.
module life_grid_generation_engine #(
  parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            row_valid_i,
  output logic                            row_stall_o,
  input  logic [lge_pkg::ROW_W-1:0]       row_cells_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lge_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lge_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            result_valid_o,
  input  logic                            result_stall_i,
  output logic [lge_pkg::ROW_W-1:0]       result_row_cells_o,
  output logic [lge_pkg::GRID_AW-1:0]     result_row_index_o,
  output logic                            last_row_o
);
  import lge_pkg::*;

  // commands from the sequencer, status back from the datapath
  lge_cmd_t    cmd;
  lge_status_t status;

  lge_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_valid_i (row_valid_i),
    .row_stall_o (row_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lge_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .row_cells_i        (row_cells_i),
    .result_valid_o     (result_valid_o),
    .result_stall_i     (result_stall_i),
    .result_row_cells_o (result_row_cells_o),
    .result_row_index_o (result_row_index_o),
    .last_row_o         (last_row_o)
  );

endmodule

### rtl/lge_checker.sv
// lge_checker: port-level assertions for life_grid_generation_engine.
// Depends on lge_pkg; attached to the top level by the bind below.
module lge_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            row_stall_o,
  input logic                            result_valid_o,
  input logic                            result_stall_i,
  input logic [lge_pkg::ROW_W-1:0]       result_row_cells_o,
  input logic [lge_pkg::GRID_AW-1:0]     result_row_index_o,
  input logic                            last_row_o
);
  import lge_pkg::*;

  // hold a stalled result word
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o)
    else $error("result valid dropped while stalled");

  // hold the payload of a stalled result word
  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=>
      ($stable(result_row_cells_o) && $stable(result_row_index_o) &&
       $stable(last_row_o)))
    else $error("result payload changed while stalled");

  // input stays stalled while a non-final row of a grid is out
  a_load_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_row_o |-> row_stall_o)
    else $error("input open during emission");

  // one read per word: an accepted word leaves a bubble
  a_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_stall_i |=> !result_valid_o)
    else $error("result word without read bubble");

  // advance row index by one from word to word
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_stall_i && !last_row_o |-> ##2
      (result_valid_o &&
       result_row_index_o == $past(result_row_index_o, 2) + 6'd1))
    else $error("result row index out of sequence");

endmodule

bind life_grid_generation_engine lge_checker u_lge_checker (.*);

### dv/tb_life_grid_generation_engine.sv
// Self-checking bench for life_grid_generation_engine: loads grids row by row, runs
// Life generations in a bit-sliced predictor and checks every emitted row word.
// Depends on lge_pkg and the RTL of the engine.
`timescale 1ns / 1ps

module tb_life_grid_generation_engine;

  // Grid limits of the block as built with its default parameters
  localparam int GRID_ROWS = (lge_pkg::DEF_MAX_ROWS < lge_pkg::GRID_DEPTH) ?
                             lge_pkg::DEF_MAX_ROWS : lge_pkg::GRID_DEPTH;
  localparam int GRID_COLS = (lge_pkg::DEF_MAX_COLS < lge_pkg::ROW_W) ?
                             lge_pkg::DEF_MAX_COLS : lge_pkg::ROW_W;
  localparam int RANDOM_ROWS = 440;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [lge_pkg::ROW_W-1:0]   cells;
    logic [lge_pkg::GRID_AW-1:0] index;
    logic                        last;
  } grid_row_t;

  // Mirror of the engine: registers, the grid under load, and the rows
  // still owed by the block in emission order.
  class life_scoreboard;
    logic [lge_pkg::CNT_W-1:0] row_count_q;
    logic [lge_pkg::CNT_W-1:0] col_count_q;
    logic                      wrap_q;
    logic [lge_pkg::GEN_W-1:0] gen_count_q;
    logic [lge_pkg::ROW_W-1:0] grid_q [GRID_ROWS];
    int unsigned               rows_in_q;
    grid_row_t                 rows_due_q [$];
    int unsigned               mismatches;

    function new();
      row_count_q = lge_pkg::ROW_COUNT_RST;
      col_count_q = lge_pkg::COL_COUNT_RST;
      wrap_q      = lge_pkg::WRAP_RST;
      gen_count_q = lge_pkg::GEN_COUNT_RST;
      rows_in_q   = 0;
      mismatches  = 0;
    endfunction

    function void set_register(lge_pkg::cfg_idx_e idx, logic [lge_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        lge_pkg::CFG_ROW_COUNT: row_count_q = data[lge_pkg::CNT_W-1:0];
        lge_pkg::CFG_COL_COUNT: col_count_q = data[lge_pkg::CNT_W-1:0];
        lge_pkg::CFG_WRAP:      wrap_q      = data[0];
        lge_pkg::CFG_GEN_COUNT: gen_count_q = data[lge_pkg::GEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Rows in use: zero acts as one, large values saturate
    function int unsigned grid_rows();
      int unsigned r;
      r = row_count_q;
      if (r < 1) r = 1;
      if (r > GRID_ROWS) r = GRID_ROWS;
      return r;
    endfunction

    function int unsigned pending();
      return rows_due_q.size();
    endfunction

    // One generation over the whole grid, one 64-bit row at a time
    function void evolve(int unsigned rows, int unsigned cols, logic [63:0] msk);
      logic [63:0] src [3];
      logic [63:0] nb [8];
      logic [63:0] nxt [GRID_ROWS];
      logic [63:0] lft, rgt, s0, s1, s2, s3, c0, c1, c2;
      int unsigned n;
      for (int x = 0; x < rows; x++) begin
        src[1] = grid_q[x];
        if (wrap_q) begin
          src[0] = grid_q[(x == 0) ? rows - 1 : x - 1];
          src[2] = grid_q[(x + 1 >= rows) ? x + 1 - rows : x + 1];
        end else begin
          src[0] = (x == 0) ? '0 : grid_q[x - 1];
          src[2] = (x + 1 >= rows) ? '0 : grid_q[x + 1];
        end
        // Gather the eight neighbor planes; on a torus a position that folds
        // back onto the cell or another neighbor is counted every time
        n = 0;
        for (int r = 0; r < 3; r++) begin
          if (wrap_q) begin
            lft = ((src[r] << 1) | (src[r] >> (cols - 1))) & msk;
            rgt = ((src[r] >> 1) | (src[r] << (cols - 1))) & msk;
          end else begin
            lft = (src[r] << 1) & msk;
            rgt = (src[r] >> 1) & msk;
          end
          nb[n] = lft;
          nb[n + 1] = rgt;
          n += 2;
          if (r != 1) begin
            nb[n] = src[r];
            n++;
          end
        end
        // Ripple each plane into a 4-plane count, bit 3 sticky
        s0 = '0; s1 = '0; s2 = '0; s3 = '0;
        for (int i = 0; i < 8; i++) begin
          c0 = s0 & nb[i];
          s0 ^= nb[i];
          c1 = s1 & c0;
          s1 ^= c0;
          c2 = s2 & c1;
          s2 ^= c1;
          s3 |= c2;
        end
        // Count of 2 or 3: plane 1 set, planes 2 and 3 clear; 3 births, 2 keeps
        nxt[x] = s1 & ~s2 & ~s3 & (s0 | src[1]) & msk;
      end
      for (int x = 0; x < rows; x++) grid_q[x] = nxt[x];
    endfunction

    function void note_row(logic [lge_pkg::ROW_W-1:0] cells);
      int unsigned rows, cols;
      logic [63:0] msk;
      grid_row_t   item;
      rows = grid_rows();
      cols = col_count_q;
      if (cols < 1) cols = 1;
      if (cols > GRID_COLS) cols = GRID_COLS;
      // A shift by 64 yields zero, so 64 columns give an all-ones mask
      msk = (64'd1 << cols) - 64'd1;
      // Row count lowered under a partial load: restart at row 0
      if (rows_in_q >= rows) rows_in_q = 0;
      grid_q[rows_in_q] = cells & msk;
      rows_in_q++;
      if (rows_in_q < rows) return;
      // Columns in force at the last row apply to the whole grid
      for (int k = 0; k < rows; k++) grid_q[k] &= msk;
      repeat (gen_count_q) evolve(rows, cols, msk);
      for (int k = 0; k < rows; k++) begin
        item.cells = grid_q[k];
        item.index = lge_pkg::GRID_AW'(k);
        item.last  = (k + 1 == rows);
        rows_due_q.push_back(item);
      end
      rows_in_q = 0;
    endfunction

    function void check_result(logic [lge_pkg::ROW_W-1:0] cells,
                               logic [lge_pkg::GRID_AW-1:0] index, logic last);
      grid_row_t want;
      if (rows_due_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result word with none due: cells %h row %0d last %0b",
                   $realtime, cells, index, last);
        mismatches++;
        return;
      end
      want = rows_due_q.pop_front();
      if (want.cells !== cells || want.index !== index || want.last !== last) begin
        if (mismatches < 10)
          $display("%0t: row word mismatch: expected cells %h row %0d last %0b, got cells %h row %0d last %0b",
                   $realtime, want.cells, want.index, want.last, cells, index, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            row_valid_i;
  logic                            row_stall_o;
  logic [lge_pkg::ROW_W-1:0]       row_cells_i;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [lge_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [lge_pkg::CFG_DATA_W-1:0]  cfg_data_i;
  logic                            result_valid_o;
  logic                            result_stall_i;
  logic [lge_pkg::ROW_W-1:0]       result_row_cells_o;
  logic [lge_pkg::GRID_AW-1:0]     result_row_index_o;
  logic                            last_row_o;

  life_scoreboard          sb;
  logic [lge_pkg::ROW_W-1:0] load_rows_q [$];
  bit                      tx_calm;
  bit                      rx_calm;

  life_grid_generation_engine dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .row_valid_i        (row_valid_i),
    .row_stall_o        (row_stall_o),
    .row_cells_i        (row_cells_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .result_valid_o     (result_valid_o),
    .result_stall_i     (result_stall_i),
    .result_row_cells_o (result_row_cells_o),
    .result_row_index_o (result_row_index_o),
    .last_row_o         (last_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hang guard: far beyond the slowest legal run
  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Row mix: empty, full, sparse, dense and plain random words. Bits above
  // the column count are left random so the input masking gets exercised.
  function automatic logic [lge_pkg::ROW_W-1:0] draw_cells();
    logic [63:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return a & b & c;
      5, 6:    return a | b;
      default: return a;
    endcase
  endfunction

  // Send every queued row word; gaps are drawn per word, valid drops only
  // ahead of a gap or after the final word.
  task automatic drive_rows();
    logic [lge_pkg::ROW_W-1:0] w;
    int unsigned gap;
    while (load_rows_q.size() > 0) begin
      w = load_rows_q.pop_front();
      gap = tx_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        row_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      row_valid_i <= 1'b1;
      row_cells_i <= w;
      do @(posedge clk_i); while (row_stall_o);
      sb.note_row(w);
    end
    row_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(lge_pkg::cfg_idx_e idx, logic [lge_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the sender until every owed row word is back, then let the block
  // drain its pipeline before anything else happens
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Result side: stall each word for a drawn number of cycles, starting
  // before it shows up so the stall also lands on the first word of a grid
  initial begin : result_sink
    int unsigned gap;
    result_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        result_stall_i <= 1'b1;
        do @(posedge clk_i); while (!result_valid_o);
        repeat (gap - 1) @(posedge clk_i);
      end
      result_stall_i <= 1'b0;
      do @(posedge clk_i); while (!result_valid_o);
    end
  end

  // Check every word taken on the result channel
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && !result_stall_i)
      sb.check_result(result_row_cells_o, result_row_index_o, last_row_o);
  end

  initial begin : stimulus
    int unsigned sent, rows, p, v;
    logic [lge_pkg::CFG_DATA_W-1:0] word;
    sb = new();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rst_ni      <= 1'b0;
    row_valid_i <= 1'b0;
    row_cells_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= lge_pkg::CFG_ROW_COUNT;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Partial load under the reset row count: no word may come back
    load_rows_q = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA,
                    64'h5555_5555_5555_5555, 64'h8000_0000_0000_0001};
    drive_rows();
    settle();
    // Drop the row count below the rows already in: load restarts at row 0.
    // Columns, wrap and generations stay at reset values for this grid.
    write_reg(lge_pkg::CFG_ROW_COUNT, 16'd3);
    load_rows_q = '{64'h0, 64'hE000_0000_0000_0007, 64'h0};
    drive_rows();
    settle();

    // Zero rows and zero columns act as one; upper data bits are ignored.
    // Zero generations emit the grid as loaded.
    write_reg(lge_pkg::CFG_ROW_COUNT, 16'hFF80);
    write_reg(lge_pkg::CFG_COL_COUNT, 16'hFF80);
    write_reg(lge_pkg::CFG_GEN_COUNT, 16'd0);
    load_rows_q = '{64'hFFFF_FFFF_FFFF_FFFF};
    drive_rows();
    settle();

    // Column count above the limit saturates
    write_reg(lge_pkg::CFG_COL_COUNT, 16'h007F);
    load_rows_q = '{64'hFFFF_FFFF_FFFF_FFFF};
    drive_rows();
    settle();

    // Tiny tori: wrapped neighbors fold onto the cell itself
    write_reg(lge_pkg::CFG_COL_COUNT, 16'd1);
    write_reg(lge_pkg::CFG_WRAP, 16'hFFFF);
    write_reg(lge_pkg::CFG_GEN_COUNT, 16'd3);
    load_rows_q = '{64'h0000_0000_0000_0001};
    drive_rows();
    settle();
    write_reg(lge_pkg::CFG_ROW_COUNT, 16'd2);
    write_reg(lge_pkg::CFG_COL_COUNT, 16'd2);
    write_reg(lge_pkg::CFG_GEN_COUNT, 16'd1);
    load_rows_q = '{64'h3, 64'h1};
    drive_rows();
    settle();
    write_reg(lge_pkg::CFG_ROW_COUNT, 16'd3);
    write_reg(lge_pkg::CFG_COL_COUNT, 16'd3);
    write_reg(lge_pkg::CFG_GEN_COUNT, 16'd2);
    load_rows_q = '{64'h2, 64'h7, 64'h4};
    drive_rows();
    settle();

    // Column count changed halfway through a load: the final one masks all rows
    write_reg(lge_pkg::CFG_ROW_COUNT, 16'd4);
    write_reg(lge_pkg::CFG_COL_COUNT, 16'd64);
    write_reg(lge_pkg::CFG_WRAP, 16'd0);
    write_reg(lge_pkg::CFG_GEN_COUNT, 16'd1);
    load_rows_q = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    drive_rows();
    settle();
    write_reg(lge_pkg::CFG_COL_COUNT, 16'd5);
    load_rows_q = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    drive_rows();
    settle();

    // Longest generation run, on a single row to keep it short
    write_reg(lge_pkg::CFG_ROW_COUNT, 16'd1);
    write_reg(lge_pkg::CFG_COL_COUNT, 16'd64);
    write_reg(lge_pkg::CFG_GEN_COUNT, 16'hFFFF);
    load_rows_q = '{64'hFFFF_FFFF_FFFF_FFFF};
    drive_rows();

    // Random grids. Retune most of the time (after a full drain), otherwise
    // push the next grid right behind the one still emitting.
    sent = 0;
    while (sent < RANDOM_ROWS) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      rx_calm = ($urandom_range(0, 5) == 0);
      if (sent == 0 || $urandom_range(0, 4) < 3) begin
        settle();
        if (sent == 0 || $urandom_range(0, 1)) begin
          p = $urandom_range(0, 99);
          if (p < 65)      v = $urandom_range(1, 8);
          else if (p < 85) v = $urandom_range(9, 24);
          else if (p < 95) v = $urandom_range(25, 64);
          else if (p < 98) v = $urandom_range(65, 127);
          else             v = 0;
          word = {9'($urandom_range(0, 511)), 7'(v)};
          write_reg(lge_pkg::CFG_ROW_COUNT, word);
        end
        if ($urandom_range(0, 1)) begin
          p = $urandom_range(0, 99);
          if (p < 10)      v = 0;
          else if (p < 20) v = $urandom_range(65, 127);
          else             v = $urandom_range(1, 64);
          word = {9'($urandom_range(0, 511)), 7'(v)};
          write_reg(lge_pkg::CFG_COL_COUNT, word);
        end
        if ($urandom_range(0, 1)) begin
          word = {15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1))};
          write_reg(lge_pkg::CFG_WRAP, word);
        end
        // Long runs only on short grids so the run stays bounded
        p = $urandom_range(0, 99);
        if (p < 40)                   v = $urandom_range(0, 4);
        else if (sb.grid_rows() > 8)  v = $urandom_range(5, 40);
        else if (p < 80)              v = $urandom_range(5, 64);
        else                          v = $urandom_range(65, 400);
        write_reg(lge_pkg::CFG_GEN_COUNT, 16'(v));
      end
      rows = sb.grid_rows();
      repeat (rows) load_rows_q.push_back(draw_cells());
      drive_rows();
      sent += rows;
    end

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
